/* rtl/fcce_pkg.sv */
// Shared codes, widths and reset values for the cluster chain table engine.
package fcce_pkg;

  // Operation codes carried in the input transaction
  localparam logic [1:0] OP_FIND_FREE  = 2'd0;
  localparam logic [1:0] OP_WRITE      = 2'd1;
  localparam logic [1:0] OP_FREE_CHAIN = 2'd2;
  localparam logic [1:0] OP_FIND_END   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_CHAIN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_FREE_CODE  = 2'd0;
  localparam logic [1:0] REG_END_CODE   = 2'd1;
  localparam logic [1:0] REG_SCAN_LIMIT = 2'd2;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CLUSTER_W = 12;
  localparam int unsigned LINK_W   = 16;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;
  // Wide enough for any table index compare, including the depth itself
  localparam int unsigned CMP_W = 17;

  // Register reset values
  localparam logic [LINK_W-1:0]  FREE_CODE_RST  = 16'hFFFF;
  localparam logic [LINK_W-1:0]  END_CODE_RST   = 16'hFFFE;
  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 13'd4086;

endpackage

/* rtl/fat_cluster_chain_engine_top.sv */
// Operation: a write goes from accept to the done state and then to the output register; a free
// search visits one table entry per cycle, and a chain walk or free follows one link per cycle.
// Searches and walks are paced by the single table memory, which is read once per cycle.
// Throughput: one item at a time; the next item is taken once the current result is registered.
// Reset: control clears at once, then a clearing pass writes the reset free code into every
// table entry, with no item accepted (configuration writes still taken).
module fat_cluster_chain_engine_top #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave: [1:0] operation, [13:2] cluster, [29:14] value, [31:30] zero
  input  logic [fcce_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // master: [1:0] status, [13:2] found_cluster, [15:14] zero
  output logic [fcce_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [fcce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fcce_pkg::LINK_W-1:0]       cfg_data_i
);
  import fcce_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = (AW > CLUSTER_W) ? AW : CLUSTER_W;
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);
  localparam logic [AW-1:0]    CLR_LAST = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // configuration registers
  logic [LINK_W-1:0]  free_code_q, end_code_q;
  logic [LIMIT_W-1:0] scan_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_code_q  <= FREE_CODE_RST;
      end_code_q   <= END_CODE_RST;
      scan_limit_q <= SCAN_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FREE_CODE:  free_code_q  <= cfg_data_i;
        REG_END_CODE:   end_code_q   <= cfg_data_i;
        REG_SCAN_LIMIT: scan_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [OP_W-1:0]      in_op;
  logic [CLUSTER_W-1:0] in_cluster;
  logic [LINK_W-1:0]    in_value;
  assign in_op      = s_axis_tdata_i[1:0];
  assign in_cluster = s_axis_tdata_i[13:2];
  assign in_value   = s_axis_tdata_i[29:14];

  // control state
  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic [SW-1:0]       steps_q, steps_d;
  logic                release_q, release_d;
  logic                want_last_q, want_last_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [CLUSTER_W-1:0] res_found_q, res_found_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [CLUSTER_W-1:0] out_found_q, out_found_d;

  // table memory with registered read and write-to-read forwarding
  logic [LINK_W-1:0] mem [TABLE_DEPTH];
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [LINK_W-1:0] mem_rd_q;
  logic              fwd_hit_q;
  logic [LINK_W-1:0] fwd_data_q;
  logic [LINK_W-1:0] rdata;

  assign rd_addr = cur_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_q   <= mem[rd_addr];
    fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
    fwd_data_q <= wr_data;
  end

  assign rdata = fwd_hit_q ? fwd_data_q : mem_rd_q;

  // search bound: min(scan_limit, depth)
  logic [CMP_W-1:0] bound;
  logic [CMP_W-1:0] cur_nxt;
  logic [CMP_W-1:0] link_w;
  logic [SW-1:0]    steps_nxt;
  logic             in_acc;

  assign bound     = (CMP_W'(scan_limit_q) > DEPTH_C) ? DEPTH_C : CMP_W'(scan_limit_q);
  assign cur_nxt   = CMP_W'(cur_q) + CMP_W'(1);
  assign link_w    = CMP_W'(rdata);
  assign steps_nxt = steps_q + SW'(1);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    release_d    = release_q;
    want_last_d  = want_last_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q[AW-1:0];
    wr_data      = free_code_q;

    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = FREE_CODE_RST;
        clr_d   = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cur_d        = CW'(in_cluster);
          steps_d      = '0;
          release_d    = (in_op == OP_FREE_CHAIN);
          want_last_d  = (in_op == OP_FIND_END);
          res_status_d = ST_OK;
          res_found_d  = '0;
          unique case (in_op)
            OP_FIND_FREE: begin
              if (CMP_W'(in_cluster) >= bound) begin
                res_status_d = ST_NONE;
                state_d      = S_DONE;
              end else begin
                state_d = S_FREE;
              end
            end
            OP_WRITE: begin
              // drop writes beyond the table
              if (CMP_W'(in_cluster) < DEPTH_C) begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_cluster);
                wr_data = in_value;
              end
              state_d = S_DONE;
            end
            default: begin
              if (CMP_W'(in_cluster) >= DEPTH_C) begin
                res_status_d = ST_CHAIN;
                state_d      = S_DONE;
              end else begin
                state_d = S_WALK;
              end
            end
          endcase
        end
      end
      S_FREE: begin
        // rdata holds the entry at cur_q; the next entry is read meanwhile
        if (rdata == free_code_q) begin
          res_found_d = CLUSTER_W'(cur_q);
          state_d     = S_DONE;
        end else if (cur_nxt >= bound) begin
          res_status_d = ST_NONE;
          state_d      = S_DONE;
        end else begin
          cur_d = CW'(cur_nxt);
        end
      end
      S_WALK: begin
        wr_en = release_q;
        if (rdata == end_code_q) begin
          if (want_last_q) begin
            res_found_d = CLUSTER_W'(cur_q);
          end
          state_d = S_DONE;
        end else if (link_w >= DEPTH_C || steps_nxt == SW'(TABLE_DEPTH)) begin
          res_status_d = ST_CHAIN;
          state_d      = S_DONE;
        end else begin
          steps_d = steps_nxt;
          cur_d   = CW'(link_w);
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      steps_q     <= '0;
      release_q   <= 1'b0;
      want_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      steps_q     <= steps_d;
      release_q   <= release_d;
      want_last_q <= want_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_found_q, out_status_q};

endmodule
